// ===== src/idpu_pkg.sv =====
// Shared constants, types and the control program of the integer digit and prime unit.
package idpu_pkg;

  // Operand width; the low DATA_WIDTH bits of the value are used, sign-extended.
  localparam int DATA_WIDTH = 32;
  localparam int CMD_W      = 3;
  localparam int RESULT_W   = 35;
  // Magnitude of a digit reversal or digit sum; one bit less than the signed result.
  localparam int ACC_W      = RESULT_W - 1;
  // Trial divisors stay below sqrt(2^(DATA_WIDTH-1)) + 2.
  localparam int DIV_W      = DATA_WIDTH / 2 + 1;
  localparam int SQ_W       = DATA_WIDTH + 1;
  localparam int BCNT_W     = $clog2(DATA_WIDTH);
  // Reciprocal of ten: (m * RECIP10) >> RECIP_SHIFT is m / 10 for any 32-bit m.
  localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;
  localparam int RECIP_SHIFT = 35;
  localparam int PROD_W      = DATA_WIDTH + 32;
  localparam int UPC_W       = 4;

  typedef logic [UPC_W-1:0] upc_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_EVEN  = 3'd0,
    CMD_PRIME = 3'd1,
    CMD_PAL   = 3'd2,
    CMD_SIGN  = 3'd3,
    CMD_REV   = 3'd4,
    CMD_DSUM  = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    SIGN_ZERO = 2'd0,
    SIGN_POS  = 2'd1,
    SIGN_NEG  = 2'd2
  } sign_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_MUL10,
    OP_DIGIT,
    OP_PRIME_INIT,
    OP_SET_FLAG,
    OP_CLR_FLAG,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_NEXT_D,
    OP_EMIT
  } op_e;

  typedef enum logic [3:0] {
    C_NONE,
    C_ALWAYS,
    C_PRIME_CMD,
    C_NOT_DIGIT,
    C_WORK_ZERO,
    C_LE1,
    C_SQ_GT,
    C_DIV_BUSY,
    C_REM_NONZERO
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    upc_t  target;
  } ctrl_t;

  localparam upc_t PC_IDLE   = 4'd0;
  localparam upc_t PC_DLOOP  = 4'd3;
  localparam upc_t PC_PRIME  = 4'd6;
  localparam upc_t PC_TRIAL  = 4'd8;
  localparam upc_t PC_DIVSTP = 4'd10;
  localparam upc_t PC_EMIT   = 4'd13;

  // Control store: one word per step. A word jumps to its target when its
  // condition holds, else falls through to the next step.
  function automatic ctrl_t ucode(upc_t pc);
    ctrl_t w;
    case (pc)
      4'd0:    w = '{OP_LOAD,       C_NONE,        PC_IDLE};
      4'd1:    w = '{OP_NOP,        C_PRIME_CMD,   PC_PRIME};
      4'd2:    w = '{OP_NOP,        C_NOT_DIGIT,   PC_EMIT};
      4'd3:    w = '{OP_NOP,        C_WORK_ZERO,   PC_EMIT};
      4'd4:    w = '{OP_MUL10,      C_NONE,        PC_IDLE};
      4'd5:    w = '{OP_DIGIT,      C_ALWAYS,      PC_DLOOP};
      4'd6:    w = '{OP_PRIME_INIT, C_LE1,         PC_EMIT};
      4'd7:    w = '{OP_SET_FLAG,   C_NONE,        PC_IDLE};
      4'd8:    w = '{OP_NOP,        C_SQ_GT,       PC_EMIT};
      4'd9:    w = '{OP_DIV_INIT,   C_NONE,        PC_IDLE};
      4'd10:   w = '{OP_DIV_STEP,   C_DIV_BUSY,    PC_DIVSTP};
      4'd11:   w = '{OP_NEXT_D,     C_REM_NONZERO, PC_TRIAL};
      4'd12:   w = '{OP_CLR_FLAG,   C_ALWAYS,      PC_EMIT};
      4'd13:   w = '{OP_EMIT,       C_ALWAYS,      PC_IDLE};
      default: w = '{OP_NOP,        C_ALWAYS,      PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== src/idpu_ifs.sv =====
// Valid/ready channel interfaces for the request and result beats.
interface idpu_req_if;
  logic                                valid;
  logic                                ready;
  logic [idpu_pkg::CMD_W-1:0]          command;
  logic signed [31:0]                  value;
  modport source (output valid, command, value, input ready);
  modport sink   (input valid, command, value, output ready);
endinterface

interface idpu_rsp_if;
  logic                                valid;
  logic                                ready;
  logic                                answer_flag;
  logic [1:0]                          sign_class;
  logic signed [idpu_pkg::RESULT_W-1:0] number_result;
  logic                                status;
  modport source (output valid, answer_flag, sign_class, number_result, status,
                  input ready);
  modport sink   (input valid, answer_flag, sign_class, number_result, status,
                  output ready);
endinterface

// ===== src/integer_digit_and_prime_unit.sv =====
// Top level of the integer digit and prime unit: microcoded sequencer and datapath.
//
//   Channel   Direction  Beat contents
//   req_i     in         command (3 bits), value (32 bits signed)
//   rsp_o     out        answer_flag, sign_class, number_result (35 bits), status
//
// Parity, sign and invalid codes go straight from the load to the emit step. Digit commands
// loop once per decimal digit (zero check, multiply by 1/10, accumulate). Primality emits at
// once at or below one, else tries each trial divisor (2, then odd numbers up to the square
// root) with a bit-serial remainder.
// Reset clears the step counter and the result valid flag. A beat is taken only at the
// idle step; the emit step stalls only while an unaccepted result still fills the output.
module integer_digit_and_prime_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  idpu_req_if.sink         req_i,
  idpu_rsp_if.source       rsp_o
);

  localparam int W = idpu_pkg::DATA_WIDTH;

  // Sequencer state.
  idpu_pkg::upc_t  upc_q, upc_d;
  idpu_pkg::ctrl_t ctrl;
  logic            take_jump;
  logic            hold;

  // Operand registers captured at load.
  logic [idpu_pkg::CMD_W-1:0] cmd_q;
  logic                       neg_q;
  logic [W-1:0]               mag_q;

  // Working registers.
  logic [W-1:0]                    work_q;
  logic [idpu_pkg::ACC_W-1:0]      acc_q;
  logic [idpu_pkg::PROD_W-1:0]     prod_q;
  logic                            flag_q;
  logic [idpu_pkg::DIV_W-1:0]      dvsr_q;
  logic [idpu_pkg::SQ_W-1:0]       sq_q;
  logic [idpu_pkg::DIV_W-1:0]      rem_q;
  logic [idpu_pkg::BCNT_W-1:0]     bcnt_q;

  // Load path: sign-extend the low W bits, then take the magnitude.
  logic [W-1:0] val_low;
  logic         val_neg;
  logic [W-1:0] val_mag;

  // Digit path.
  logic [W-1:0]               quot10;
  logic [W-1:0]               digit_w;
  logic [3:0]                 digit;
  logic [idpu_pkg::ACC_W-1:0] acc_next;

  // Remainder path.
  logic [idpu_pkg::DIV_W:0]   rem_shift;
  logic                       rem_ge;
  logic [idpu_pkg::DIV_W:0]   rem_sub;

  // Result register.
  logic                            out_valid_q;
  logic                            flag_out_q, flag_out_d;
  logic [1:0]                      sign_out_q, sign_out_d;
  logic signed [idpu_pkg::RESULT_W-1:0] num_out_q, num_out_d;
  logic                            status_out_q, status_out_d;
  logic                            emit;

  assign ctrl = idpu_pkg::ucode(upc_q);

  assign val_low = req_i.value[W-1:0];
  assign val_neg = val_low[W-1];
  assign val_mag = val_neg ? (~val_low + W'(1)) : val_low;

  // Divide by ten through the registered reciprocal product.
  assign quot10  = W'(prod_q >> idpu_pkg::RECIP_SHIFT);
  assign digit_w = work_q - ((quot10 << 3) + (quot10 << 1));
  assign digit   = digit_w[3:0];
  always_comb begin
    if (cmd_q == idpu_pkg::CMD_DSUM) begin
      acc_next = acc_q + idpu_pkg::ACC_W'(digit);
    end else begin
      acc_next = (acc_q << 3) + (acc_q << 1) + idpu_pkg::ACC_W'(digit);
    end
  end

  // One restoring step: shift in the next dividend bit, subtract when it fits.
  assign rem_shift = {rem_q, work_q[W-1]};
  assign rem_ge    = rem_shift >= {1'b0, dvsr_q};
  assign rem_sub   = rem_shift - {1'b0, dvsr_q};

  // Jump conditions.
  always_comb begin
    case (ctrl.cond)
      idpu_pkg::C_NONE:        take_jump = 1'b0;
      idpu_pkg::C_ALWAYS:      take_jump = 1'b1;
      idpu_pkg::C_PRIME_CMD:   take_jump = cmd_q == idpu_pkg::CMD_PRIME;
      idpu_pkg::C_NOT_DIGIT:   take_jump = !(cmd_q == idpu_pkg::CMD_PAL ||
                                             cmd_q == idpu_pkg::CMD_REV ||
                                             cmd_q == idpu_pkg::CMD_DSUM);
      idpu_pkg::C_WORK_ZERO:   take_jump = work_q == '0;
      idpu_pkg::C_LE1:         take_jump = neg_q || (mag_q <= W'(1));
      idpu_pkg::C_SQ_GT:       take_jump = sq_q > idpu_pkg::SQ_W'(mag_q);
      idpu_pkg::C_DIV_BUSY:    take_jump = bcnt_q != idpu_pkg::BCNT_W'(W - 1);
      idpu_pkg::C_REM_NONZERO: take_jump = rem_q != '0;
      default:                 take_jump = 1'b0;
    endcase
  end

  // The idle step waits for a request; the emit step waits for a free result slot.
  assign hold = (ctrl.op == idpu_pkg::OP_LOAD && !req_i.valid) ||
                (ctrl.op == idpu_pkg::OP_EMIT && out_valid_q && !rsp_o.ready);
  assign emit = ctrl.op == idpu_pkg::OP_EMIT && !hold;

  assign req_i.ready = ctrl.op == idpu_pkg::OP_LOAD;

  always_comb begin
    if (hold) begin
      upc_d = upc_q;
    end else if (take_jump) begin
      upc_d = ctrl.target;
    end else begin
      upc_d = upc_q + idpu_pkg::UPC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= idpu_pkg::PC_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  // Datapath registers, driven by the op field of the current control word.
  always_ff @(posedge clk_i) begin
    case (ctrl.op)
      idpu_pkg::OP_LOAD: begin
        if (req_i.valid) begin
          cmd_q  <= req_i.command;
          neg_q  <= val_neg;
          mag_q  <= val_mag;
          work_q <= val_mag;
          acc_q  <= '0;
        end
      end
      idpu_pkg::OP_MUL10: begin
        prod_q <= idpu_pkg::PROD_W'(work_q) * idpu_pkg::PROD_W'(idpu_pkg::RECIP10);
      end
      idpu_pkg::OP_DIGIT: begin
        work_q <= quot10;
        acc_q  <= acc_next;
      end
      idpu_pkg::OP_PRIME_INIT: begin
        flag_q <= 1'b0;
        dvsr_q <= idpu_pkg::DIV_W'(2);
        sq_q   <= idpu_pkg::SQ_W'(4);
      end
      idpu_pkg::OP_SET_FLAG: begin
        flag_q <= 1'b1;
      end
      idpu_pkg::OP_CLR_FLAG: begin
        flag_q <= 1'b0;
      end
      idpu_pkg::OP_DIV_INIT: begin
        work_q <= mag_q;
        rem_q  <= '0;
        bcnt_q <= '0;
      end
      idpu_pkg::OP_DIV_STEP: begin
        work_q <= work_q << 1;
        rem_q  <= rem_ge ? rem_sub[idpu_pkg::DIV_W-1:0] : rem_shift[idpu_pkg::DIV_W-1:0];
        bcnt_q <= bcnt_q + idpu_pkg::BCNT_W'(1);
      end
      idpu_pkg::OP_NEXT_D: begin
        // After 2 come the odd divisors; squares follow by adding 2d+1 or 4d+4.
        if (dvsr_q == idpu_pkg::DIV_W'(2)) begin
          dvsr_q <= idpu_pkg::DIV_W'(3);
          sq_q   <= idpu_pkg::SQ_W'(9);
        end else begin
          dvsr_q <= dvsr_q + idpu_pkg::DIV_W'(2);
          sq_q   <= sq_q + (idpu_pkg::SQ_W'(dvsr_q) << 2) + idpu_pkg::SQ_W'(4);
        end
      end
      default: begin
      end
    endcase
  end

  // Result fields from the command; fields that a command does not define stay zero.
  always_comb begin
    flag_out_d   = 1'b0;
    sign_out_d   = idpu_pkg::SIGN_ZERO;
    num_out_d    = '0;
    status_out_d = 1'b0;
    case (cmd_q)
      idpu_pkg::CMD_EVEN:  flag_out_d = ~mag_q[0];
      idpu_pkg::CMD_PRIME: flag_out_d = flag_q;
      idpu_pkg::CMD_PAL:   flag_out_d = acc_q == idpu_pkg::ACC_W'(mag_q);
      idpu_pkg::CMD_SIGN: begin
        if (neg_q) begin
          sign_out_d = idpu_pkg::SIGN_NEG;
        end else if (mag_q != '0) begin
          sign_out_d = idpu_pkg::SIGN_POS;
        end
      end
      idpu_pkg::CMD_REV, idpu_pkg::CMD_DSUM: begin
        num_out_d = neg_q ? -$signed(idpu_pkg::RESULT_W'(acc_q))
                          : $signed(idpu_pkg::RESULT_W'(acc_q));
      end
      default: status_out_d = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      flag_out_q   <= flag_out_d;
      sign_out_q   <= sign_out_d;
      num_out_q    <= num_out_d;
      status_out_q <= status_out_d;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.answer_flag   = flag_out_q;
  assign rsp_o.sign_class    = sign_out_q;
  assign rsp_o.number_result = num_out_q;
  assign rsp_o.status        = status_out_q;

endmodule
